### sv/edf_pkg.sv
// Shared constants, types and the per-channel emboss arithmetic for the
// diagonal emboss filter. No dependencies.
package edf_pkg;

   localparam int DEF_MAX_WIDTH = 2048;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int COL_W   = 11;
   localparam int ROW_W   = 16;
   localparam int IMG_W_W = 12;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;

   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = IMG_W_W'(640);
   localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT = ROW_W'(480);
   localparam logic [IMG_W_W-1:0] MIN_WIDTH        = IMG_W_W'(3);
   localparam logic [ROW_W-1:0]   MIN_HEIGHT       = ROW_W'(3);

   typedef enum logic [IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_CARVE_MODE   = 2'd2
   } reg_index_type;

   typedef logic [CHAN_W-1:0] chan_type;

   // (lower_right - upper_left) + 128, reversed in carve mode, saturated to a byte
   function automatic chan_type emboss_chan(chan_type lower_right, chan_type upper_left,
                                            logic carve);
      logic signed [CHAN_W+1:0] d;
      chan_type                 res;
      if (carve) begin
         d = $signed({2'b00, upper_left}) - $signed({2'b00, lower_right});
      end else begin
         d = $signed({2'b00, lower_right}) - $signed({2'b00, upper_left});
      end
      d = d + $signed((CHAN_W+2)'(128));
      if (d < 0) begin
         res = '0;
      end else if (d > $signed((CHAN_W+2)'(255))) begin
         res = '1;
      end else begin
         res = d[CHAN_W-1:0];
      end
      return res;
   endfunction

endpackage

### sv/emboss_diagonal_filter.sv
// Diagonal emboss filter: top level with line store, delay taps and result register.
// Depends on edf_pkg.
//
// Takes one RGB pixel per unstalled clock in raster order and, for each interior
// pixel (x,y), gives per channel (P(x+1,y+1) - P(x-1,y)) + 128 clamped to 0..255,
// or the reverse difference in carve mode. The result for (x,y) enters the result
// register as pixel (x+1,y+1) is taken; border pixels give no beat. Throughput is
// one pixel per unstalled clock, set by the single-port line store, which is read
// and written at the current column in the same cycle. req_stall is high only
// while a result waits in the output register and rsp_stall holds it. Write csr
// registers between frames; the line store needs no clearing pass.
module emboss_diagonal_filter #(
   parameter int MAX_WIDTH = edf_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [edf_pkg::CHAN_W-1:0]    req_chan0_in,
   input  logic [edf_pkg::CHAN_W-1:0]    req_chan1_in,
   input  logic [edf_pkg::CHAN_W-1:0]    req_chan2_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [edf_pkg::COL_W-1:0]     rsp_out_col,
   output logic [edf_pkg::ROW_W-1:0]     rsp_out_row,
   output logic [edf_pkg::CHAN_W-1:0]    rsp_chan0_out,
   output logic [edf_pkg::CHAN_W-1:0]    rsp_chan1_out,
   output logic [edf_pkg::CHAN_W-1:0]    rsp_chan2_out,
   output logic                          rsp_frame_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [edf_pkg::IDX_W-1:0]     csr_index,
   input  logic [edf_pkg::CSR_W-1:0]     csr_wdata
);
   import edf_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int MW_W   = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (MW_W > IMG_W_W) ? MW_W : IMG_W_W;
   localparam logic [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);

   // configuration
   logic [IMG_W_W-1:0] image_width_ff;
   logic [ROW_W-1:0]   image_height_ff;
   logic               carve_mode_ff;
   logic               csr_wr;

   // stream state
   logic [ADDR_W-1:0]  col_count_ff, col_count_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [PIX_W-1:0]   row_store [MAX_WIDTH];
   logic [PIX_W-1:0]   above_ff;      // newest upper tap, memory read register
   logic [PIX_W-1:0]   upper_ff;      // older upper tap

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   out_col_ff;
   logic [ROW_W-1:0]   out_row_ff;
   logic [CHAN_W-1:0]  chan0_ff, chan1_ff, chan2_ff;
   logic               frame_last_ff;

   logic               accept;
   logic [PIX_W-1:0]   pix;
   logic [IMG_W_W-1:0] w_lo;
   logic [EW-1:0]      eff_w;
   logic [ROW_W-1:0]   eff_h;
   logic [EW-1:0]      col_ext;
   logic [EW-1:0]      col_nxt;
   logic [EW-1:0]      col_m1;
   logic [ROW_W:0]     row_nxt;
   logic [ROW_W-1:0]   row_m1;
   logic               emit;
   logic               last;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         carve_mode_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata[ROW_W-1:0];
            REG_CARVE_MODE:   carve_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pix       = {req_chan2_in, req_chan1_in, req_chan0_in};

   always_comb begin
      w_lo  = (image_width_ff < MIN_WIDTH) ? MIN_WIDTH : image_width_ff;
      eff_w = (EW'(w_lo) > MAX_W_EXT) ? MAX_W_EXT : EW'(w_lo);
      eff_h = (image_height_ff < MIN_HEIGHT) ? MIN_HEIGHT : image_height_ff;

      col_ext = EW'(col_count_ff);
      col_nxt = col_ext + EW'(1);
      col_m1  = col_ext - EW'(1);
      row_nxt = {1'b0, row_count_ff} + (ROW_W+1)'(1);
      row_m1  = row_count_ff - ROW_W'(1);

      emit = (col_ext >= EW'(2)) && (col_ext < eff_w) &&
             (row_count_ff >= ROW_W'(2)) && (row_count_ff < eff_h);
      last = (col_nxt == eff_w) && (row_nxt == {1'b0, eff_h});

      if (col_nxt >= eff_w) begin
         col_count_in = '0;
         row_count_in = (row_nxt >= {1'b0, eff_h}) ? '0 : row_nxt[ROW_W-1:0];
      end else begin
         col_count_in = col_nxt[ADDR_W-1:0];
         row_count_in = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // read-first line store and the two upper taps
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff                <= row_store[col_count_ff];
         row_store[col_count_ff] <= pix;
         upper_ff                <= above_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_col_ff    <= col_m1[COL_W-1:0];
         out_row_ff    <= row_m1;
         chan0_ff      <= emboss_chan(pix[CHAN_W-1:0], upper_ff[CHAN_W-1:0],
                                      carve_mode_ff);
         chan1_ff      <= emboss_chan(pix[2*CHAN_W-1:CHAN_W], upper_ff[2*CHAN_W-1:CHAN_W],
                                      carve_mode_ff);
         chan2_ff      <= emboss_chan(pix[3*CHAN_W-1:2*CHAN_W],
                                      upper_ff[3*CHAN_W-1:2*CHAN_W], carve_mode_ff);
         frame_last_ff <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_chan0_out  = chan0_ff;
   assign rsp_chan1_out  = chan1_ff;
   assign rsp_chan2_out  = chan2_ff;
   assign rsp_frame_last = frame_last_ff;

endmodule
